// File: hdl/subpel_bicubic_interpolator_macros.svh
// Assertion macros for the sub-pel interpolator checker.
`ifndef SUBPEL_BICUBIC_INTERPOLATOR_MACROS_SVH
`define SUBPEL_BICUBIC_INTERPOLATOR_MACROS_SVH

// Checked only outside reset.
`define SBI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sbi assertion failed");

// Checked at every edge, reset included.
`define SBI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sbi assertion failed");

`endif

// File: hdl/sbi_pkg.sv
package sbi_pkg;

    localparam int PHASE_BITS_DEF = 4;
    localparam int PHASE_W        = 4;
    localparam int PIX_W          = 8;
    localparam int ROW_PIX_W      = 32;
    localparam int NTAPS          = 4;
    localparam int TAP_W          = 8;
    localparam int HACC_W         = 20;
    localparam int ROW_W          = 12;
    localparam int VACC_W         = 22;
    localparam int RND_SHIFT      = 6;
    localparam int RND_BIAS       = 32;
    localparam int TAP_SUM        = 64;
    localparam int PIX_MAX        = 255;

    typedef logic signed [TAP_W-1:0] tap_t;
    typedef tap_t [NTAPS-1:0] tap_row_t;
    typedef logic signed [ROW_W-1:0] row_val_t;

    // Catmull-Rom taps for phase p of 2^pb, scaled by 64, row sum forced to 64
    function automatic tap_row_t rom_row(input int p, input int pb);
        longint n;
        longint n2;
        longint n3;
        longint q;
        longint q2;
        longint q3;
        longint v [NTAPS];
        longint t [NTAPS];
        longint sum;
        int big;
        tap_row_t res;
        n   = longint'(1) << pb;
        n2  = n * n;
        n3  = n2 * n;
        q   = longint'(p);
        q2  = q * q;
        q3  = q2 * q;
        v[0] = 32 * (-q * n2 + 2 * q2 * n - q3);
        v[1] = 64 * n3 - 160 * q2 * n + 96 * q3;
        v[2] = 32 * q * n2 + 128 * q2 * n - 96 * q3;
        v[3] = -32 * q2 * n + 32 * q3;
        sum = 0;
        for (int i = 0; i < NTAPS; i++) begin
            t[i] = (v[i] + (n3 >>> 1)) >>> (3 * pb);
            sum  = sum + t[i];
        end
        big = 1;
        for (int i = 0; i < NTAPS; i++) begin
            if (t[i] > t[big]) begin
                big = i;
            end
        end
        t[big] = t[big] + longint'(TAP_SUM) - sum;
        for (int i = 0; i < NTAPS; i++) begin
            res[i] = t[i][TAP_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: hdl/subpel_bicubic_interpolator.sv
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | phase_x, phase_y, window_row_0..3
// m_      | out       | m_valid / m_ready  | pixel_out
//
// One transfer per clock while the output is not stalled; stages: tap lookup, four row lanes, vertical merge.
// Each stage holds when the stage after it is full and stalled; bubbles are squeezed out.
// Synchronous active-low reset clears the stage valid bits only.
module subpel_bicubic_interpolator #(
    parameter int PHASE_BITS = sbi_pkg::PHASE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sbi_pkg::PHASE_W-1:0]      s_phase_x,
    input  logic [sbi_pkg::PHASE_W-1:0]      s_phase_y,
    input  logic [sbi_pkg::ROW_PIX_W-1:0]    s_window_row_0,
    input  logic [sbi_pkg::ROW_PIX_W-1:0]    s_window_row_1,
    input  logic [sbi_pkg::ROW_PIX_W-1:0]    s_window_row_2,
    input  logic [sbi_pkg::ROW_PIX_W-1:0]    s_window_row_3,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sbi_pkg::PIX_W-1:0]        m_pixel_out
);

    localparam int NPH = 1 << PHASE_BITS;

    sbi_pkg::tap_row_t rom [NPH];
    logic [PHASE_BITS-1:0] idx_x;
    logic [PHASE_BITS-1:0] idx_y;

    for (genvar p = 0; p < NPH; p++) begin : g_rom
        assign rom[p] = sbi_pkg::rom_row(p, PHASE_BITS);
    end

    if (PHASE_BITS <= sbi_pkg::PHASE_W) begin : g_idx_narrow
        assign idx_x = s_phase_x[PHASE_BITS-1:0];
        assign idx_y = s_phase_y[PHASE_BITS-1:0];
    end else begin : g_idx_wide
        assign idx_x = {{(PHASE_BITS-sbi_pkg::PHASE_W){1'b0}}, s_phase_x};
        assign idx_y = {{(PHASE_BITS-sbi_pkg::PHASE_W){1'b0}}, s_phase_y};
    end

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic rdy1, rdy2, rdy3;

    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_comb begin
        v1_next = rdy1 ? s_valid : v1_reg;
        v2_next = rdy2 ? v1_reg  : v2_reg;
        v3_next = rdy3 ? v2_reg  : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // stage 1: taps and window
    sbi_pkg::tap_row_t hx_reg;
    sbi_pkg::tap_row_t hy_reg;
    logic [sbi_pkg::ROW_PIX_W-1:0] win_reg [sbi_pkg::NTAPS];

    always_ff @(posedge aclk) begin
        if (s_valid && rdy1) begin
            hx_reg     <= rom[idx_x];
            hy_reg     <= rom[idx_y];
            win_reg[0] <= s_window_row_0;
            win_reg[1] <= s_window_row_1;
            win_reg[2] <= s_window_row_2;
            win_reg[3] <= s_window_row_3;
        end
    end

    // stage 2: horizontal lanes
    logic load2;
    sbi_pkg::tap_row_t hy_s2_reg;
    sbi_pkg::row_val_t row_val [sbi_pkg::NTAPS];

    assign load2 = v1_reg && rdy2;

    always_ff @(posedge aclk) begin
        if (load2) begin
            hy_s2_reg <= hy_reg;
        end
    end

    for (genvar j = 0; j < sbi_pkg::NTAPS; j++) begin : g_lane
        sbi_row_lane u_lane (
            .aclk    (aclk),
            .load    (load2),
            .taps    (hx_reg),
            .pixels  (win_reg[j]),
            .row_val (row_val[j])
        );
    end

    // stage 3: vertical merge and output register
    sbi_merge u_merge (
        .aclk    (aclk),
        .load    (v2_reg && rdy3),
        .taps    (hy_s2_reg),
        .row_val (row_val),
        .pixel   (m_pixel_out)
    );

    assign m_valid = v3_reg;

endmodule

// File: hdl/sbi_row_lane.sv
module sbi_row_lane (
    input  logic                                aclk,
    input  logic                                load,
    input  sbi_pkg::tap_row_t                   taps,
    input  logic [sbi_pkg::ROW_PIX_W-1:0]       pixels,
    output sbi_pkg::row_val_t                   row_val
);

    logic signed [sbi_pkg::HACC_W-1:0] acc;
    logic signed [sbi_pkg::HACC_W-1:0] rnd;
    sbi_pkg::row_val_t                 row_val_reg;

    always_comb begin
        acc = '0;
        for (int i = 0; i < sbi_pkg::NTAPS; i++) begin
            acc = acc + sbi_pkg::HACC_W'($signed(taps[i]) *
                  $signed({1'b0, pixels[i*sbi_pkg::PIX_W +: sbi_pkg::PIX_W]}));
        end
        rnd = (acc + sbi_pkg::HACC_W'(sbi_pkg::RND_BIAS)) >>> sbi_pkg::RND_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            row_val_reg <= rnd[sbi_pkg::ROW_W-1:0];
        end
    end

    assign row_val = row_val_reg;

endmodule

// File: hdl/sbi_merge.sv
module sbi_merge (
    input  logic                         aclk,
    input  logic                         load,
    input  sbi_pkg::tap_row_t            taps,
    input  sbi_pkg::row_val_t            row_val [sbi_pkg::NTAPS],
    output logic [sbi_pkg::PIX_W-1:0]    pixel
);

    logic signed [sbi_pkg::VACC_W-1:0] acc;
    logic signed [sbi_pkg::VACC_W-1:0] rnd;
    logic [sbi_pkg::PIX_W-1:0]         pix_next;
    logic [sbi_pkg::PIX_W-1:0]         pix_reg;

    always_comb begin
        acc = '0;
        for (int j = 0; j < sbi_pkg::NTAPS; j++) begin
            acc = acc + sbi_pkg::VACC_W'($signed(taps[j]) * row_val[j]);
        end
        rnd = (acc + sbi_pkg::VACC_W'(sbi_pkg::RND_BIAS)) >>> sbi_pkg::RND_SHIFT;
        if (rnd < 0) begin
            pix_next = '0;
        end else if (rnd > sbi_pkg::VACC_W'(sbi_pkg::PIX_MAX)) begin
            pix_next = sbi_pkg::PIX_W'(sbi_pkg::PIX_MAX);
        end else begin
            pix_next = rnd[sbi_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg <= pix_next;
        end
    end

    assign pixel = pix_reg;

endmodule

// File: hdl/sbi_checker.sv
`include "subpel_bicubic_interpolator_macros.svh"

module sbi_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [sbi_pkg::PIX_W-1:0]     m_pixel_out
);

    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (s_valid && s_ready && !(m_valid && m_ready)) begin
            cnt_next = cnt_reg + 3'd1;
        end else if (!(s_valid && s_ready) && m_valid && m_ready) begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `SBI_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)
    `SBI_ASSERT(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready)
    `SBI_ASSERT(a_inflight_bound, aclk, aresetn, cnt_reg <= 3'd3)
    `SBI_ASSERT(a_no_phantom, aclk, aresetn, m_valid |-> cnt_reg != 3'd0)
    `SBI_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_pixel_out))

endmodule

bind subpel_bicubic_interpolator sbi_checker u_sbi_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_pixel_out (m_pixel_out)
);

// File: sim/subpel_checker.sv
`timescale 1ns / 1ps

module subpel_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [sbi_pkg::PHASE_W-1:0]    s_phase_x,
    input  logic [sbi_pkg::PHASE_W-1:0]    s_phase_y,
    input  logic [sbi_pkg::ROW_PIX_W-1:0]  s_window_row_0,
    input  logic [sbi_pkg::ROW_PIX_W-1:0]  s_window_row_1,
    input  logic [sbi_pkg::ROW_PIX_W-1:0]  s_window_row_2,
    input  logic [sbi_pkg::ROW_PIX_W-1:0]  s_window_row_3,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [sbi_pkg::PIX_W-1:0]      m_pixel_out,
    output int                             outstanding,
    output int                             fail_count
);

    localparam int ROM_BITS = sbi_pkg::PHASE_BITS_DEF;

    typedef logic signed [31:0] weight_t;
    typedef weight_t [3:0] weight_row_t;
    typedef logic [3:0][sbi_pkg::ROW_PIX_W-1:0] window_t;
    typedef logic [sbi_pkg::PIX_W-1:0] pixel_t;

    pixel_t expected_pixels [$];
    pixel_t want;

    // Catmull-Rom weights at phase/2^ROM_BITS, x64, rounded, row sum forced to 64
    function automatic weight_row_t cubic_weights(input int phase);
        longint n;
        longint n2;
        longint n3;
        longint q;
        longint q2;
        longint q3;
        longint raw [4];
        longint total;
        int peak;
        weight_row_t w;
        n  = longint'(1) << ROM_BITS;
        n2 = n * n;
        n3 = n2 * n;
        q  = longint'(phase);
        q2 = q * q;
        q3 = q2 * q;
        raw[0] = 32 * (-q * n2 + 2 * q2 * n - q3);
        raw[1] = 64 * n3 - 160 * q2 * n + 96 * q3;
        raw[2] = 32 * q * n2 + 128 * q2 * n - 96 * q3;
        raw[3] = -32 * q2 * n + 32 * q3;
        total = 0;
        for (int i = 0; i < 4; i++) begin
            raw[i] = (raw[i] + n3 / 2) >>> (3 * ROM_BITS);
            total  = total + raw[i];
        end
        // largest weight; ties go to tap 1, else to the lower tap index
        peak = 1;
        for (int i = 0; i < 4; i++) begin
            if (raw[i] > raw[peak]) begin
                peak = i;
            end
        end
        raw[peak] = raw[peak] + longint'(sbi_pkg::TAP_SUM) - total;
        for (int i = 0; i < 4; i++) begin
            w[i] = weight_t'(raw[i]);
        end
        return w;
    endfunction

    function automatic pixel_t bicubic_pixel(
        input logic [sbi_pkg::PHASE_W-1:0] phase_x,
        input logic [sbi_pkg::PHASE_W-1:0] phase_y,
        input window_t                     window
    );
        weight_row_t wx;
        weight_row_t wy;
        longint row_val [4];
        longint acc;
        wx = cubic_weights(int'(phase_x) % (1 << ROM_BITS));
        wy = cubic_weights(int'(phase_y) % (1 << ROM_BITS));
        for (int j = 0; j < 4; j++) begin
            acc = 0;
            for (int i = 0; i < 4; i++) begin
                acc = acc + longint'(signed'(wx[i])) * longint'(window[j][8*i +: 8]);
            end
            row_val[j] = (acc + sbi_pkg::RND_BIAS) >>> sbi_pkg::RND_SHIFT;
        end
        acc = 0;
        for (int j = 0; j < 4; j++) begin
            acc = acc + longint'(signed'(wy[j])) * row_val[j];
        end
        acc = (acc + sbi_pkg::RND_BIAS) >>> sbi_pkg::RND_SHIFT;
        if (acc < 0) begin
            acc = 0;
        end else if (acc > sbi_pkg::PIX_MAX) begin
            acc = sbi_pkg::PIX_MAX;
        end
        return pixel_t'(acc);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_pixels.delete();
            outstanding = 0;
            fail_count  = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_pixels.push_back(bicubic_pixel(s_phase_x, s_phase_y,
                    {s_window_row_3, s_window_row_2, s_window_row_1, s_window_row_0}));
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_out: expected no transfer, actual %0d", m_pixel_out);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want !== m_pixel_out) begin
                        $error("pixel_out: expected %0d, actual %0d", want, m_pixel_out);
                        fail_count++;
                    end
                end
            end
            outstanding = expected_pixels.size();
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [sbi_pkg::PHASE_W-1:0] phase_t;
    typedef logic [sbi_pkg::ROW_PIX_W-1:0] row_t;
    typedef enum int {SINK_FREE, SINK_HALF, SINK_SLOW, SINK_TOGGLE} sink_mode_e;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    phase_t                    s_phase_x = '0;
    phase_t                    s_phase_y = '0;
    row_t                      s_window_row_0 = '0;
    row_t                      s_window_row_1 = '0;
    row_t                      s_window_row_2 = '0;
    row_t                      s_window_row_3 = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [sbi_pkg::PIX_W-1:0] m_pixel_out;

    int outstanding;
    int fail_count;
    int sent = 0;
    int cycles = 0;
    int burst_left = 0;
    int max_gap = 4;

    always #1 aclk = ~aclk;

    subpel_bicubic_interpolator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_phase_x      (s_phase_x),
        .s_phase_y      (s_phase_y),
        .s_window_row_0 (s_window_row_0),
        .s_window_row_1 (s_window_row_1),
        .s_window_row_2 (s_window_row_2),
        .s_window_row_3 (s_window_row_3),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out)
    );

    subpel_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_phase_x      (s_phase_x),
        .s_phase_y      (s_phase_y),
        .s_window_row_0 (s_window_row_0),
        .s_window_row_1 (s_window_row_1),
        .s_window_row_2 (s_window_row_2),
        .s_window_row_3 (s_window_row_3),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out),
        .outstanding    (outstanding),
        .fail_count     (fail_count)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // some rows saturated per byte to push rows past the pixel range
    function automatic row_t random_pixel_row();
        row_t w;
        w = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            for (int b = 0; b < 4; b++) begin
                w[8*b +: 8] = {8{w[8*b]}};
            end
        end
        return w;
    endfunction

    task automatic offer(input phase_t px, input phase_t py,
                         input row_t r0, input row_t r1, input row_t r2, input row_t r3);
        int gap;
        s_valid        <= 1'b1;
        s_phase_x      <= px;
        s_phase_y      <= py;
        s_window_row_0 <= r0;
        s_window_row_1 <= r1;
        s_window_row_2 <= r2;
        s_window_row_3 <= r3;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin : sender
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // phase zero passes the center pixel through
        offer(4'd0, 4'd0, random_pixel_row(), random_pixel_row(), random_pixel_row(),
              random_pixel_row());
        offer(4'd15, 4'd15, 32'h0, 32'h0, 32'h0, 32'h0);
        offer(4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(4'd8, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // overshoot clamps high, undershoot with negative rows clamps low
        offer(4'd8, 4'd8, 32'h0, 32'h00FF_FF00, 32'h00FF_FF00, 32'h0);
        offer(4'd8, 4'd8, 32'hFFFF_FFFF, 32'hFF00_00FF, 32'hFF00_00FF, 32'hFFFF_FFFF);
        offer(4'd0, 4'd15, 32'h00FF_00FF, 32'hFF00_FF00, 32'h00FF_00FF, 32'hFF00_FF00);
        offer(4'd15, 4'd0, 32'hFF00_FF00, 32'h00FF_00FF, 32'hFF00_FF00, 32'h00FF_00FF);
        for (int i = 0; i < 16; i++) begin
            offer(phase_t'(i), phase_t'(i * 7), random_pixel_row(), random_pixel_row(),
                  random_pixel_row(), random_pixel_row());
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 200 == 0) begin
                max_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            offer(phase_t'($urandom), phase_t'($urandom), random_pixel_row(),
                  random_pixel_row(), random_pixel_row(), random_pixel_row());
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin : receiver
        int seg;
        sink_mode_e mode;
        bit held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            seg  = $urandom_range(10, 150);
            mode = sink_mode_e'($urandom_range(0, 3));
            repeat (seg) begin
                @(posedge aclk);
                if (!held && sent >= HOLD_AFTER) begin
                    // long back-pressure so the pipeline fills and stalls its input
                    held = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (mode)
                    SINK_FREE: begin
                        m_ready <= 1'b1;
                    end
                    SINK_HALF: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    SINK_SLOW: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_ready <= ~m_ready;
                    end
                endcase
            end
        end
    end

endmodule
